// File: src/midtone_autostretch_pixel_unit_assert.svh
// assertion macros used by the checker file
`ifndef MIDTONE_AUTOSTRETCH_PIXEL_UNIT_ASSERT_SVH
`define MIDTONE_AUTOSTRETCH_PIXEL_UNIT_ASSERT_SVH

// antecedent implies consequent on the next clock
`define MTFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent on the same clock
`define MTFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// File: src/mtfs_pkg.sv
// shared types and constants of the midtone stretch unit
`default_nettype none
package mtfs_pkg;
    localparam int NUM_W = 48;
    localparam int DEN_W = 36;
    localparam int SUM_W = 40;

    typedef enum logic [1:0] {
        MODE_ACC   = 2'd0,
        MODE_AUTO  = 2'd1,
        MODE_SQRT  = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MDIV = 7'b0000010,
        ST_MULT = 7'b0000100,
        ST_CALC = 7'b0001000,
        ST_QDIV = 7'b0010000,
        ST_SQRT = 7'b0100000,
        ST_FIN  = 7'b1000000
    } state_t;
endpackage
`default_nettype wire

// File: src/mtfs_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none
module mtfs_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [mtfs_pkg::NUM_W-1:0] num,
    input  wire logic [mtfs_pkg::DEN_W-1:0] den,
    output logic                            done,
    output logic [mtfs_pkg::NUM_W-1:0]      quot
);
    import mtfs_pkg::*;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg, num_next;
    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    // one restoring step
    always_comb
    begin
        trial = {rem_reg, num_reg[NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = trial >= {1'b0, den_reg};
    end

    // iteration control
    always_comb
    begin
        num_next  = num_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            quot_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next  = {num_reg[NUM_W-2:0], 1'b0};
            quot_next = {quot_reg[NUM_W-2:0], ge};
            rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
endmodule
`default_nettype wire

// File: src/midtone_autostretch_pixel_unit.sv
// Order: accumulate and clear finish at acceptance; square root: ST_SQRT, ST_FIN;
// autostretch: ST_MDIV (mean divide), ST_MULT (serial multiply), ST_CALC (setup),
// ST_QDIV (quotient divide), ST_FIN (output); zero tally or bad channel skips to ST_FIN,
// zero denominator from ST_CALC. One item at a time; next request taken the cycle after
// the result loads, later while a result waits.
// Reset: asynchronous active low, clears channel sums, tallies and control state.
`default_nettype none
module midtone_autostretch_pixel_unit #(
    parameter int CHANNELS   = 3,
    parameter int TALLY_BITS = 24
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  mode,
    input  wire logic [1:0]  channel,
    input  wire logic [15:0] pixel,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      stretched,
    output logic [1:0]       out_channel
);
    import mtfs_pkg::*;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    state_t              state_reg, state_next;
    logic [SUM_W-1:0]    sum_reg [CHANNELS];
    logic [TALLY_BITS-1:0] tally_reg [CHANNELS];
    logic [1:0]          ch_reg, ch_next;
    logic [15:0]         pix_reg, pix_next;
    logic [15:0]         mean_reg, mean_next;
    logic [31:0]         prod_reg, prod_next;
    logic [31:0]         mcand_reg, mcand_next;
    logic [15:0]         mplier_reg, mplier_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic [15:0]         res_reg, res_next;
    logic [31:0]         sq_val_reg, sq_val_next;
    logic [18:0]         sq_rem_reg, sq_rem_next;
    logic [15:0]         sq_root_reg, sq_root_next;
    logic                out_valid_reg, out_valid_next;
    logic [15:0]         out_data_reg, out_data_next;
    logic [1:0]          out_ch_reg, out_ch_next;

    logic                accept;
    logic [CH_IDX_W-1:0] ch_idx;
    logic                ch_ok;
    logic [SUM_W:0]      sum_add;
    logic                div_start;
    logic [NUM_W-1:0]    div_num;
    logic [DEN_W-1:0]    div_den;
    logic                div_done;
    logic [NUM_W-1:0]    div_quot;
    logic [31:0]         p65535;
    logic [31:0]         t_val;
    logic [NUM_W-1:0]    n_val;
    logic [37:0]         d_val;
    logic                d_pos;
    logic [18:0]         sq_trial_rem;
    logic [18:0]         sq_trial;
    logic                sq_ge;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign ch_idx   = channel[CH_IDX_W-1:0];
    assign ch_ok    = channel < CHANNELS;
    assign sum_add  = {1'b0, sum_reg[ch_idx]} + (SUM_W + 1)'(pixel);

    // numerator and denominator of the rational transfer function
    always_comb
    begin
        p65535 = {pix_reg, 16'h0} - {16'h0, pix_reg};
        t_val  = p65535 - prod_reg;
        n_val  = {t_val, 16'h0} - {16'h0, t_val};
        d_val  = {4'b0, mean_reg, 18'b0} - {20'b0, mean_reg, 2'b0}
               - ({4'b0, prod_reg, 2'b0} + {6'b0, prod_reg})
               + {6'b0, p65535};
        d_pos  = !d_val[37] && (d_val != '0);
    end

    // square root step, two radicand bits per cycle
    always_comb
    begin
        sq_trial_rem = {sq_rem_reg[16:0], sq_val_reg[31:30]};
        sq_trial     = {1'b0, sq_root_reg, 2'b01};
        sq_ge        = sq_trial_rem >= sq_trial;
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        ch_next      = ch_reg;
        pix_next     = pix_reg;
        mean_next    = mean_reg;
        prod_next    = prod_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        cnt_next     = cnt_reg;
        res_next     = res_reg;
        sq_val_next  = sq_val_reg;
        sq_rem_next  = sq_rem_reg;
        sq_root_next = sq_root_reg;
        div_start    = 1'b0;
        div_num      = NUM_W'(sum_reg[ch_idx]);
        div_den      = DEN_W'(tally_reg[ch_idx]);
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ch_next  = channel;
                    pix_next = pixel;
                    if (mode == MODE_AUTO)
                    begin
                        if (!ch_ok || tally_reg[ch_idx] == '0)
                        begin
                            res_next   = '0;
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = ST_MDIV;
                        end
                    end
                    else if (mode == MODE_SQRT)
                    begin
                        sq_val_next  = {pixel, 16'h0} - {16'h0, pixel};
                        sq_rem_next  = '0;
                        sq_root_next = '0;
                        cnt_next     = '0;
                        state_next   = ST_SQRT;
                    end
                end
            end
            ST_MDIV:
            begin
                if (div_done)
                begin
                    mean_next   = (div_quot > NUM_W'(16'hFFFF)) ? 16'hFFFF : div_quot[15:0];
                    mcand_next  = (div_quot > NUM_W'(16'hFFFF)) ? 32'h0000FFFF
                                                               : {16'h0, div_quot[15:0]};
                    mplier_next = pix_reg;
                    prod_next   = '0;
                    cnt_next    = '0;
                    state_next  = ST_MULT;
                end
            end
            ST_MULT:
            begin
                if (mplier_reg[0])
                begin
                    prod_next = prod_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[30:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[15:1]};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == 4'd15)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (d_pos)
                begin
                    div_start  = 1'b1;
                    div_num    = n_val;
                    div_den    = d_val[DEN_W-1:0];
                    state_next = ST_QDIV;
                end
                else
                begin
                    res_next   = '0;
                    state_next = ST_FIN;
                end
            end
            ST_QDIV:
            begin
                if (div_done)
                begin
                    res_next   = (div_quot > NUM_W'(16'hFFFF)) ? 16'hFFFF : div_quot[15:0];
                    state_next = ST_FIN;
                end
            end
            ST_SQRT:
            begin
                sq_val_next  = {sq_val_reg[29:0], 2'b00};
                sq_rem_next  = sq_ge ? (sq_trial_rem - sq_trial) : sq_trial_rem;
                sq_root_next = {sq_root_reg[14:0], sq_ge};
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == 4'd15)
                begin
                    res_next   = {sq_root_reg[14:0], sq_ge};
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_ch_next    = out_ch_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == ST_FIN && (!out_valid_reg || out_ready))
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_reg;
            out_ch_next    = ch_reg;
        end
    end

    // channel statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                sum_reg[c]   <= '0;
                tally_reg[c] <= '0;
            end
        end
        else if (accept && mode == MODE_CLEAR)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                sum_reg[c]   <= '0;
                tally_reg[c] <= '0;
            end
        end
        else if (accept && mode == MODE_ACC && ch_ok)
        begin
            sum_reg[ch_idx] <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
            if (tally_reg[ch_idx] != '1)
            begin
                tally_reg[ch_idx] <= tally_reg[ch_idx] + 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        ch_reg       <= ch_next;
        pix_reg      <= pix_next;
        mean_reg     <= mean_next;
        prod_reg     <= prod_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        res_reg      <= res_next;
        sq_val_reg   <= sq_val_next;
        sq_rem_reg   <= sq_rem_next;
        sq_root_reg  <= sq_root_next;
        out_data_reg <= out_data_next;
        out_ch_reg   <= out_ch_next;
    end

    mtfs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign out_valid   = out_valid_reg;
    assign stretched   = out_data_reg;
    assign out_channel = out_ch_reg;
endmodule
`default_nettype wire

// File: src/mtfs_checker.sv
// port-level checker for the midtone stretch unit and its bind
`default_nettype none
`include "midtone_autostretch_pixel_unit_assert.svh"
module mtfs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [1:0]  mode,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] stretched
);
    import mtfs_pkg::*;

    // a stalled result stays
    `MTFS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    // a stalled result keeps its value
    `MTFS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(stretched))
    // a square root request occupies the unit
    `MTFS_ASSERT_NEXT(a_sqrt_busy, clk, rst_n, in_valid && in_ready && mode == MODE_SQRT,
        !in_ready)
    // an accumulate request never makes a result appear
    `MTFS_ASSERT_NEXT(a_acc_silent, clk, rst_n, in_valid && in_ready && mode == MODE_ACC,
        !$rose(out_valid))
endmodule

bind midtone_autostretch_pixel_unit mtfs_checker u_mtfs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stretched (stretched)
);
`default_nettype wire
